// ----- rtl/ddo_pkg.sv -----
// shared types, constants and tables for the differential drive odometry block
// no dependencies
package ddo_pkg;

   localparam int DIV_W        = 64;
   localparam int CORDIC_STEPS = 30;

   localparam logic [29:0] BAM_PER_RAD = 30'd683565276;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [44:0] AM_CLAMP = 45'd1 << 44;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] RATE_MAX = 64'd1 << 31;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_LEFT_MPT  = 2'd0;
   localparam csr_idx_type CSR_RIGHT_MPT = 2'd1;
   localparam csr_idx_type CSR_WHEEL_BASE = 2'd2;
   localparam csr_idx_type CSR_MODE = 2'd3;

   typedef logic [4:0] op_type;
   localparam op_type OP_NONE       = 5'd0;
   localparam op_type OP_CAPTURE    = 5'd1;
   localparam op_type OP_PRIME      = 5'd2;
   localparam op_type OP_TRAV_L     = 5'd3;
   localparam op_type OP_TRAV_R     = 5'd4;
   localparam op_type OP_SUMS       = 5'd5;
   localparam op_type OP_TURN_START = 5'd6;
   localparam op_type OP_TURN_TAKE  = 5'd7;
   localparam op_type OP_AM_TAKE    = 5'd8;
   localparam op_type OP_COR0_PLAIN = 5'd9;
   localparam op_type OP_COR0_ARC   = 5'd10;
   localparam op_type OP_COR1_TAKE  = 5'd11;
   localparam op_type OP_FX_TAKE    = 5'd12;
   localparam op_type OP_FY_TAKE    = 5'd13;
   localparam op_type OP_MUL_X      = 5'd14;
   localparam op_type OP_ADD_X      = 5'd15;
   localparam op_type OP_MUL_Y      = 5'd16;
   localparam op_type OP_ADD_Y      = 5'd17;
   localparam op_type OP_LIN_START  = 5'd18;
   localparam op_type OP_LIN_TAKE   = 5'd19;
   localparam op_type OP_ANG_TAKE   = 5'd20;
   localparam op_type OP_VEL_ZERO   = 5'd21;
   localparam op_type OP_FINISH     = 5'd22;

   typedef struct packed {
      logic   req_ready;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic primed;
      logic div_done;
      logic cor_done;
      logic turn_zero;
      logic first_order;
      logic dt_zero;
      logic rsp_free;
   } status_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ddo_if.sv -----
// valid/ready channel interfaces for odometry samples and pose results
// no dependencies
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_count;
   logic signed [31:0] right_count;
   logic [31:0]        time_us;

   modport source (output valid, left_count, right_count, time_us, input ready);
   modport sink (input valid, left_count, right_count, time_us, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] angular_velocity;
   logic               velocity_valid;

   modport source (output valid, pos_x, pos_y, heading, linear_velocity,
                   angular_velocity, velocity_valid, input ready);
   modport sink (input valid, pos_x, pos_y, heading, linear_velocity,
                 angular_velocity, velocity_valid, output ready);
endinterface

// ----- rtl/differential_drive_odometry.sv -----
// differential drive wheel odometry, top level
// depends on ddo_pkg, ddo_if, ddo_ctrl and ddo_dp
//
// req_ch carries one transaction per sample: left and right encoder counts and
// a microsecond timestamp. The first sample after reset only primes the stored
// counts and time and produces no rsp_ch transaction. Each later sample yields
// one rsp_ch transaction with the integrated pose, heading as a binary angle,
// linear and angular velocity and a velocity valid flag.
// Registers on the csr_ apb port: 0x0 left metres per tick, 0x4 right metres
// per tick, 0x8 wheel base, 0xC first order mode; write them only while idle.
// One sample is processed at a time. A full sample uses the shared radix-2
// divider for four divisions in zeroth order mode and six in first order mode
// with a nonzero turn (two fewer when no time has passed), and the cordic for
// one or two rotations.
// Results wait in an output register; when the receiver stalls, the next
// sample is processed up to the result and then held until the register frees.
// Reset clears the pose, the primed flag and the registers to their defaults.
module differential_drive_odometry #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ddo_req_if.sink     req_ch,
   ddo_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   ddo_pkg::cmd_type    cmd;
   ddo_pkg::status_type st;

   assign csr_pready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   ddo_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .st          (st)
   );
endmodule

// ----- rtl/ddo_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
// depends on ddo_pkg
module ddo_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddo_pkg::DIV_W-1:0]   num,
   input  logic [ddo_pkg::DIV_W-1:0]   den,
   output logic                        busy,
   output logic                        done,
   output logic [ddo_pkg::DIV_W-1:0]   quo
);
   localparam int W = ddo_pkg::DIV_W;
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      fits = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? W'(trial - {1'b0, den_ff}) : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo = quo_ff;
endmodule

// ----- rtl/ddo_cordic.sv -----
// iterative rotation-mode cordic giving cos and sin of a binary angle in q1.30
// depends on ddo_pkg
module ddo_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               busy,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic [4:0]         idx_ff, idx_in;
   logic               flip_ff, flip_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [31:0]        a_plus, a_fold;
   logic signed [33:0] dx, dy, at;

   always_comb begin
      a_plus = angle + 32'h40000000;
      a_fold = a_plus[31] ? angle - 32'h80000000 : angle;
      dx = y_ff >>> idx_ff;
      dy = x_ff >>> idx_ff;
      at = 34'(ddo_pkg::atan_bam(idx_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      c_in = c_ff;
      s_in = s_ff;
      idx_in = idx_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = ddo_pkg::GAIN_Q30;
         y_in = '0;
         z_in = 34'(signed'(a_fold));
         flip_in = a_plus[31];
         idx_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         idx_in = 5'(idx_ff + 1'b1);
         if (idx_ff == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            c_in = flip_ff ? -x_in : x_in;
            s_in = flip_ff ? -y_in : y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      c_ff <= c_in;
      s_ff <= s_in;
      idx_ff <= idx_in;
      flip_ff <= flip_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign cos_out = c_ff;
   assign sin_out = s_ff;
endmodule

// ----- rtl/ddo_ctrl.sv -----
// sequencer that steps the odometry datapath through one sample
// depends on ddo_pkg
module ddo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::status_type st,
   output ddo_pkg::cmd_type    cmd
);
   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_CHECK      = 5'd1;
   localparam logic [4:0] S_TRAV_R     = 5'd2;
   localparam logic [4:0] S_SUMS       = 5'd3;
   localparam logic [4:0] S_TURN_START = 5'd4;
   localparam logic [4:0] S_W_TURN     = 5'd5;
   localparam logic [4:0] S_W_AM       = 5'd6;
   localparam logic [4:0] S_W_COR0     = 5'd7;
   localparam logic [4:0] S_W_COR1     = 5'd8;
   localparam logic [4:0] S_W_FX       = 5'd9;
   localparam logic [4:0] S_W_FY       = 5'd10;
   localparam logic [4:0] S_MUL_X      = 5'd11;
   localparam logic [4:0] S_ADD_X      = 5'd12;
   localparam logic [4:0] S_MUL_Y      = 5'd13;
   localparam logic [4:0] S_ADD_Y      = 5'd14;
   localparam logic [4:0] S_RATE       = 5'd15;
   localparam logic [4:0] S_W_LIN      = 5'd16;
   localparam logic [4:0] S_W_ANG      = 5'd17;
   localparam logic [4:0] S_OUT        = 5'd18;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.req_ready = 1'b0;
      cmd.op = ddo_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (st.req_valid) begin
               cmd.op = ddo_pkg::OP_CAPTURE;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!st.primed) begin
               cmd.op = ddo_pkg::OP_PRIME;
               state_in = S_IDLE;
            end else begin
               cmd.op = ddo_pkg::OP_TRAV_L;
               state_in = S_TRAV_R;
            end
         end
         S_TRAV_R: begin
            cmd.op = ddo_pkg::OP_TRAV_R;
            state_in = S_SUMS;
         end
         S_SUMS: begin
            cmd.op = ddo_pkg::OP_SUMS;
            state_in = S_TURN_START;
         end
         S_TURN_START: begin
            cmd.op = ddo_pkg::OP_TURN_START;
            state_in = S_W_TURN;
         end
         S_W_TURN: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_TURN_TAKE;
               state_in = S_W_AM;
            end
         end
         S_W_AM: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_AM_TAKE;
               state_in = S_W_COR0;
            end
         end
         S_W_COR0: begin
            if (st.cor_done) begin
               if (st.first_order && !st.turn_zero) begin
                  cmd.op = ddo_pkg::OP_COR0_ARC;
                  state_in = S_W_COR1;
               end else begin
                  cmd.op = ddo_pkg::OP_COR0_PLAIN;
                  state_in = S_MUL_X;
               end
            end
         end
         S_W_COR1: begin
            if (st.cor_done) begin
               cmd.op = ddo_pkg::OP_COR1_TAKE;
               state_in = S_W_FX;
            end
         end
         S_W_FX: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_FX_TAKE;
               state_in = S_W_FY;
            end
         end
         S_W_FY: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_FY_TAKE;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            cmd.op = ddo_pkg::OP_MUL_X;
            state_in = S_ADD_X;
         end
         S_ADD_X: begin
            cmd.op = ddo_pkg::OP_ADD_X;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.op = ddo_pkg::OP_MUL_Y;
            state_in = S_ADD_Y;
         end
         S_ADD_Y: begin
            cmd.op = ddo_pkg::OP_ADD_Y;
            state_in = S_RATE;
         end
         S_RATE: begin
            if (st.dt_zero) begin
               cmd.op = ddo_pkg::OP_VEL_ZERO;
               state_in = S_OUT;
            end else begin
               cmd.op = ddo_pkg::OP_LIN_START;
               state_in = S_W_LIN;
            end
         end
         S_W_LIN: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_LIN_TAKE;
               state_in = S_W_ANG;
            end
         end
         S_W_ANG: begin
            if (st.div_done) begin
               cmd.op = ddo_pkg::OP_ANG_TAKE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (st.rsp_free) begin
               cmd.op = ddo_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/ddo_dp.sv -----
// odometry datapath: registers, wheel travel, pose and velocity arithmetic
// depends on ddo_pkg, ddo_if, ddo_div and ddo_cordic
module ddo_dp #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   ddo_req_if.sink             req_ch,
   ddo_rsp_if.source           rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   input  ddo_pkg::cmd_type    cmd,
   output ddo_pkg::status_type st
);
   localparam int DW = ddo_pkg::DIV_W;

   logic [31:0] lmpt_ff, rmpt_ff, base_ff;
   logic        mode_ff;
   logic        primed_ff;
   logic [31:0] lc_ff, rc_ff, tu_ff;
   logic [31:0] prev_left_ff, prev_right_ff, prev_time_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff;
   logic [31:0] acc_head_ff;
   logic signed [31:0] dl_ff, dr_ff, ds_ff;
   logic        diff_neg_ff;
   logic [32:0] dm_ff;
   logic [DW-1:0] turn_mag_ff;
   logic [31:0] turn_bam_ff;
   logic [44:0] am_ff;
   logic signed [33:0] c0_ff, s0_ff, c1_ff;
   logic        nsgn_ff;
   logic signed [31:0] fx_ff, fy_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] lin_ff, ang_ff;
   logic        rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_head_ff, rsp_lin_ff, rsp_ang_ff;
   logic        rsp_vv_ff;

   ddo_pkg::op_type op;
   logic          csr_wr;
   logic [31:0]   base_eff;
   logic [COUNT_WIDTH-1:0] dl_raw, dr_raw;
   logic signed [32:0] dl_cnt, dr_cnt, t_cnt;
   logic [31:0]   t_mag, t_mpt;
   logic [63:0]   t_prod;
   logic [47:0]   t_m;
   logic signed [31:0] t_res;
   logic signed [32:0] sum33, sum_adj, diff33;
   logic [31:0]   dt;
   logic [31:0]   t_head;
   logic signed [34:0] numx, numy;
   logic [33:0]   numx_mag, numy_mag;
   logic [31:0]   ds_mag;
   logic [30:0]   fm;
   logic signed [31:0] fac;
   logic [31:0]   vm;
   logic signed [31:0] vel;
   logic signed [31:0] mul_f;
   logic signed [63:0] mul_res;
   logic signed [33:0] dstep;
   logic signed [34:0] acc_sum;
   logic signed [31:0] acc_sat;
   logic          div_start, div_busy, div_done;
   logic [DW-1:0] div_num, div_den, div_quo;
   logic          cor_start, cor_busy, cor_done;
   logic [31:0]   cor_angle;
   logic signed [33:0] cor_cos, cor_sin;

   assign op = cmd.op;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign base_eff = (base_ff == 32'd0) ? 32'd1 : base_ff;
   assign dt = tu_ff - prev_time_ff;

   always_comb begin
      case (csr_paddr[3:2])
         ddo_pkg::CSR_LEFT_MPT:   csr_prdata = lmpt_ff;
         ddo_pkg::CSR_RIGHT_MPT:  csr_prdata = rmpt_ff;
         ddo_pkg::CSR_WHEEL_BASE: csr_prdata = base_ff;
         ddo_pkg::CSR_MODE:       csr_prdata = {31'd0, mode_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // wheel travel
   always_comb begin
      dl_raw = lc_ff[COUNT_WIDTH-1:0] - prev_left_ff[COUNT_WIDTH-1:0];
      dr_raw = rc_ff[COUNT_WIDTH-1:0] - prev_right_ff[COUNT_WIDTH-1:0];
      dl_cnt = 33'(signed'(dl_raw));
      dr_cnt = 33'(signed'(dr_raw));
      t_cnt = (op == ddo_pkg::OP_TRAV_R) ? dr_cnt : dl_cnt;
      t_mpt = (op == ddo_pkg::OP_TRAV_R) ? rmpt_ff : lmpt_ff;
      t_mag = t_cnt[32] ? 32'(-t_cnt) : 32'(t_cnt);
      t_prod = 64'(t_mag) * 64'(t_mpt);
      t_m = t_prod[63:16];
      if (t_cnt[32]) begin
         t_res = (t_m > 48'h80000000) ? 32'sh80000000 : 32'(-t_m);
      end else begin
         t_res = (t_m > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(t_m);
      end
   end

   always_comb begin
      sum33 = 33'(dl_ff) + 33'(dr_ff);
      sum_adj = sum33 + $signed({32'd0, sum33[32]});
      diff33 = 33'(dr_ff) - 33'(dl_ff);
      t_head = acc_head_ff + turn_bam_ff;
      numx = 35'(cor_sin) - 35'(s0_ff);
      numy = 35'(c0_ff) - 35'(c1_ff);
      numx_mag = numx[34] ? 34'(-numx) : 34'(numx);
      numy_mag = numy[34] ? 34'(-numy) : 34'(numy);
      ds_mag = ds_ff[31] ? 32'(-ds_ff) : 32'(ds_ff);
      fm = (div_quo > ddo_pkg::ONE_Q30) ? 31'(ddo_pkg::ONE_Q30) : div_quo[30:0];
      fac = (nsgn_ff ^ diff_neg_ff) ? -32'(fm) : 32'(fm);
      vm = (div_quo > ddo_pkg::RATE_MAX) ? 32'h80000000 : div_quo[31:0];
   end

   // shared divider operands
   always_comb begin
      div_start = 1'b1;
      div_num = '0;
      div_den = DW'(base_eff);
      case (op)
         ddo_pkg::OP_TURN_START: div_num = DW'(dm_ff) * DW'(ddo_pkg::BAM_PER_RAD);
         ddo_pkg::OP_TURN_TAKE:  div_num = DW'({dm_ff, 16'd0});
         ddo_pkg::OP_COR1_TAKE: begin
            div_num = DW'(numx_mag) * DW'(ddo_pkg::BAM_PER_RAD);
            div_den = turn_mag_ff;
         end
         ddo_pkg::OP_FX_TAKE: begin
            div_num = DW'(numy_mag) * DW'(ddo_pkg::BAM_PER_RAD);
            div_den = turn_mag_ff;
         end
         ddo_pkg::OP_LIN_START: begin
            div_num = DW'(ds_mag) * DW'(ddo_pkg::USEC_PER_SEC);
            div_den = DW'(dt);
         end
         ddo_pkg::OP_LIN_TAKE: begin
            div_num = DW'(am_ff) * DW'(ddo_pkg::USEC_PER_SEC);
            div_den = DW'(dt);
         end
         default: div_start = 1'b0;
      endcase
   end

   always_comb begin
      vel = (op == ddo_pkg::OP_LIN_TAKE ? ds_ff[31] : diff_neg_ff) ? -vm :
            ((vm == 32'h80000000) ? 32'sh7FFFFFFF : vm);
      cor_start = (op == ddo_pkg::OP_AM_TAKE) || (op == ddo_pkg::OP_COR0_ARC);
      cor_angle = (op == ddo_pkg::OP_COR0_ARC) ? t_head : acc_head_ff;
      mul_f = (op == ddo_pkg::OP_MUL_Y) ? fy_ff : fx_ff;
      mul_res = ds_ff * mul_f;
      dstep = 34'(prod_ff >>> 30);
      acc_sum = ((op == ddo_pkg::OP_ADD_Y) ? 35'(acc_y_ff) : 35'(acc_x_ff)) + 35'(dstep);
      if (acc_sum > 35'sd2147483647) begin
         acc_sat = 32'sh7FFFFFFF;
      end else if (acc_sum < -35'sd2147483648) begin
         acc_sat = 32'sh80000000;
      end else begin
         acc_sat = 32'(acc_sum);
      end
   end

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .busy    (cor_busy),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   always_ff @(posedge clock) begin
      case (op)
         ddo_pkg::OP_CAPTURE: begin
            lc_ff <= req_ch.left_count;
            rc_ff <= req_ch.right_count;
            tu_ff <= req_ch.time_us;
         end
         ddo_pkg::OP_TRAV_L: dl_ff <= t_res;
         ddo_pkg::OP_TRAV_R: dr_ff <= t_res;
         ddo_pkg::OP_SUMS: begin
            ds_ff <= 32'(sum_adj >>> 1);
            diff_neg_ff <= diff33[32];
            dm_ff <= diff33[32] ? 33'(-diff33) : 33'(diff33);
         end
         ddo_pkg::OP_TURN_TAKE: begin
            turn_mag_ff <= div_quo;
            turn_bam_ff <= diff_neg_ff ? -div_quo[31:0] : div_quo[31:0];
         end
         ddo_pkg::OP_AM_TAKE: begin
            am_ff <= (div_quo > DW'(ddo_pkg::AM_CLAMP)) ? ddo_pkg::AM_CLAMP : div_quo[44:0];
         end
         ddo_pkg::OP_COR0_PLAIN: begin
            fx_ff <= 32'(cor_cos);
            fy_ff <= 32'(cor_sin);
         end
         ddo_pkg::OP_COR0_ARC: begin
            c0_ff <= cor_cos;
            s0_ff <= cor_sin;
         end
         ddo_pkg::OP_COR1_TAKE: begin
            c1_ff <= cor_cos;
            nsgn_ff <= numx[34];
         end
         ddo_pkg::OP_FX_TAKE: begin
            fx_ff <= fac;
            nsgn_ff <= numy[34];
         end
         ddo_pkg::OP_FY_TAKE: fy_ff <= fac;
         ddo_pkg::OP_MUL_X: prod_ff <= mul_res;
         ddo_pkg::OP_MUL_Y: prod_ff <= mul_res;
         ddo_pkg::OP_LIN_TAKE: lin_ff <= vel;
         ddo_pkg::OP_ANG_TAKE: ang_ff <= vel;
         ddo_pkg::OP_VEL_ZERO: begin
            lin_ff <= '0;
            ang_ff <= '0;
         end
         default: begin
         end
      endcase
      if (op == ddo_pkg::OP_PRIME || op == ddo_pkg::OP_FINISH) begin
         prev_left_ff <= lc_ff;
         prev_right_ff <= rc_ff;
         prev_time_ff <= tu_ff;
      end
      if (op == ddo_pkg::OP_FINISH) begin
         rsp_x_ff <= acc_x_ff;
         rsp_y_ff <= acc_y_ff;
         rsp_head_ff <= t_head;
         rsp_lin_ff <= lin_ff;
         rsp_ang_ff <= ang_ff;
         rsp_vv_ff <= (dt != 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lmpt_ff <= '0;
         rmpt_ff <= '0;
         base_ff <= 32'd65536;
         mode_ff <= 1'b0;
         primed_ff <= 1'b0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[3:2])
               ddo_pkg::CSR_LEFT_MPT:   lmpt_ff <= csr_pwdata;
               ddo_pkg::CSR_RIGHT_MPT:  rmpt_ff <= csr_pwdata;
               ddo_pkg::CSR_WHEEL_BASE: base_ff <= csr_pwdata;
               ddo_pkg::CSR_MODE:       mode_ff <= csr_pwdata[0];
               default: begin
               end
            endcase
         end
         if (op == ddo_pkg::OP_PRIME) begin
            primed_ff <= 1'b1;
         end
         if (op == ddo_pkg::OP_ADD_X) begin
            acc_x_ff <= acc_sat;
         end
         if (op == ddo_pkg::OP_ADD_Y) begin
            acc_y_ff <= acc_sat;
         end
         if (op == ddo_pkg::OP_FINISH) begin
            acc_head_ff <= t_head;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ch.ready = cmd.req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pos_x = rsp_x_ff;
   assign rsp_ch.pos_y = rsp_y_ff;
   assign rsp_ch.heading = rsp_head_ff;
   assign rsp_ch.linear_velocity = rsp_lin_ff;
   assign rsp_ch.angular_velocity = rsp_ang_ff;
   assign rsp_ch.velocity_valid = rsp_vv_ff;

   assign st.req_valid = req_ch.valid;
   assign st.primed = primed_ff;
   assign st.div_done = div_done;
   assign st.cor_done = cor_done;
   assign st.turn_zero = (turn_mag_ff == '0);
   assign st.first_order = mode_ff;
   assign st.dt_zero = (dt == 32'd0);
   assign st.rsp_free = !rsp_valid_ff || rsp_ch.ready;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider started while busy");

   a_cor_idle_start: assert property (@(posedge clock) disable iff (reset)
      cor_start |-> !cor_busy) else $error("cordic started while busy");

   a_primed_sticks: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff) else $error("primed flag dropped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (op == ddo_pkg::OP_FINISH) |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("pending transaction overwritten");

   a_vel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_vv_ff) |-> (rsp_lin_ff == 32'sd0 && rsp_ang_ff == 32'sd0))
      else $error("velocity nonzero with zero elapsed time");
endmodule

// ----- tb/sv/odometry_checker.sv -----
`timescale 1ns / 100ps
// transaction monitor, pose predictor and result comparison for the odometry block
// depends on ddo_pkg and ddo_if
module odometry_checker (
   input  logic        clock,
   input  logic        reset,
   ddo_req_if          req_ch,
   ddo_rsp_if          rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
      logic               velocity_valid;
   } pose_type;

   localparam bit [31:0] ARC_TAB [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
   localparam longint RAD_TO_BAM = 683565276;
   localparam longint CORDIC_GAIN = 652032874;

   pose_type  expected_poses[$];
   bit [31:0] left_mpt, right_mpt, base_reg;
   bit        arc_mode, primed;
   bit [31:0] last_left, last_right, last_stamp;
   bit [31:0] x_acc, y_acc, head_acc;
   int        mismatches;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit [63:0] mag_of(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint as_s32(bit [31:0] v);
      bit signed [31:0] s;
      s = v;
      return longint'(s);
   endfunction

   function automatic longint wheel_travel(bit [31:0] cur, bit [31:0] old, bit [31:0] mpt);
      longint    d;
      bit [63:0] m;
      d = as_s32(cur - old);
      m = (mag_of(d) * {32'd0, mpt}) >> 16;
      return sat32(d < 0 ? -longint'(m) : longint'(m));
   endfunction

   function automatic void rotate(input bit [31:0] a, output longint c, output longint s);
      bit [31:0] t;
      bit        flip;
      longint    x, y, z, dx, dy;
      t = a + 32'h4000_0000;
      flip = t[31];
      if (flip) a = a - 32'h8000_0000;
      z = as_s32(a);
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ARC_TAB[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ARC_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint arc_of(longint num, longint turn);
      bit [63:0] m;
      m = mag_of(num) * 64'(RAD_TO_BAM) / mag_of(turn);
      if (m > 64'd1073741824) m = 64'd1073741824;
      return ((num < 0) != (turn < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint rate_of(bit [63:0] m, bit neg, bit [31:0] dt);
      bit [63:0] q;
      q = m * 64'd1000000 / {32'd0, dt};
      if (q > 64'd2147483648) q = 64'd2147483648;
      return sat32(neg ? -longint'(q) : longint'(q));
   endfunction

   function automatic bit advance_pose(bit [31:0] lc, bit [31:0] rc, bit [31:0] tu,
                                       output pose_type p);
      longint    dl, dr, ds, diff, turn, c0, s0, c1, s1, dx, dy, lin, ang;
      bit [63:0] base, dm, am;
      bit [31:0] t1, dt;
      if (!primed) begin
         last_left = lc; last_right = rc; last_stamp = tu;
         primed = 1'b1;
         return 1'b0;
      end
      dl = wheel_travel(lc, last_left, left_mpt);
      dr = wheel_travel(rc, last_right, right_mpt);
      ds = (dl + dr) / 2;
      diff = dr - dl;
      base = (base_reg != 0) ? {32'd0, base_reg} : 64'd1;
      dm = mag_of(diff);
      turn = longint'(dm * 64'(RAD_TO_BAM) / base);
      if (diff < 0) turn = -turn;
      am = (dm << 16) / base;
      if (am > (64'd1 << 44)) am = 64'd1 << 44;
      t1 = head_acc + turn[31:0];
      rotate(head_acc, c0, s0);
      if (arc_mode && turn != 0) begin
         rotate(t1, c1, s1);
         dx = (ds * arc_of(s1 - s0, turn)) >>> 30;
         dy = (ds * arc_of(c0 - c1, turn)) >>> 30;
      end else begin
         dx = (ds * c0) >>> 30;
         dy = (ds * s0) >>> 30;
      end
      x_acc = 32'(sat32(as_s32(x_acc) + dx));
      y_acc = 32'(sat32(as_s32(y_acc) + dy));
      head_acc = t1;
      dt = tu - last_stamp;
      lin = 0;
      ang = 0;
      if (dt != 0) begin
         lin = rate_of(mag_of(ds), ds < 0, dt);
         ang = rate_of(am, diff < 0, dt);
      end
      last_left = lc; last_right = rc; last_stamp = tu;
      p.pos_x = x_acc;
      p.pos_y = y_acc;
      p.heading = head_acc;
      p.linear_velocity = lin[31:0];
      p.angular_velocity = ang[31:0];
      p.velocity_valid = (dt != 0);
      return 1'b1;
   endfunction

   task automatic report(string what, longint exp_v, longint act_v);
      fail_count++;
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      pose_type e, got;
      if (reset) begin
         left_mpt = '0; right_mpt = '0; base_reg = 32'd65536; arc_mode = 1'b0;
         primed = 1'b0; x_acc = '0; y_acc = '0; head_acc = '0;
         last_left = '0; last_right = '0; last_stamp = '0;
         expected_poses.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (ddo_pkg::csr_idx_type'(csr_paddr >> 2))
               ddo_pkg::CSR_LEFT_MPT:   left_mpt = csr_pwdata;
               ddo_pkg::CSR_RIGHT_MPT:  right_mpt = csr_pwdata;
               ddo_pkg::CSR_WHEEL_BASE: base_reg = csr_pwdata;
               ddo_pkg::CSR_MODE:       arc_mode = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pos_x = rsp_ch.pos_x;
            got.pos_y = rsp_ch.pos_y;
            got.heading = rsp_ch.heading;
            got.linear_velocity = rsp_ch.linear_velocity;
            got.angular_velocity = rsp_ch.angular_velocity;
            got.velocity_valid = rsp_ch.velocity_valid;
            if (expected_poses.size() == 0) begin
               report("unexpected transaction, pos_x", 0, got.pos_x);
            end else begin
               e = expected_poses.pop_front();
               if (e.pos_x !== got.pos_x) report("pos_x", e.pos_x, got.pos_x);
               if (e.pos_y !== got.pos_y) report("pos_y", e.pos_y, got.pos_y);
               if (e.heading !== got.heading) report("heading", e.heading, got.heading);
               if (e.linear_velocity !== got.linear_velocity)
                  report("linear_velocity", e.linear_velocity, got.linear_velocity);
               if (e.angular_velocity !== got.angular_velocity)
                  report("angular_velocity", e.angular_velocity, got.angular_velocity);
               if (e.velocity_valid !== got.velocity_valid)
                  report("velocity_valid", e.velocity_valid, got.velocity_valid);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (advance_pose(req_ch.left_count, req_ch.right_count, req_ch.time_us, e))
               expected_poses.push_back(e);
         end
      end
      pending <= expected_poses.size();
   end

   initial begin
      fail_count = 0;
      mismatches = 0;
      pending = 0;
   end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// stimulus, register setup and verdict for the differential drive odometry block
// depends on ddo_pkg, ddo_if, odometry_checker and the block itself
module testbench;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   bit          burst, hold_request;
   bit [31:0]   left_pos, right_pos, stamp;

   ddo_req_if req_if ();
   ddo_rsp_if rsp_if ();

   differential_drive_odometry uut (
      .clock(clock), .reset(reset), .req_ch(req_if.sink), .rsp_ch(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   odometry_checker check (
      .clock(clock), .reset(reset), .req_ch(req_if), .rsp_ch(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   task automatic csr_write(ddo_pkg::csr_idx_type idx, bit [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_odometry(bit [31:0] lm, bit [31:0] rm, bit [31:0] wb, bit mode);
      csr_write(ddo_pkg::CSR_LEFT_MPT, lm);
      csr_write(ddo_pkg::CSR_RIGHT_MPT, rm);
      csr_write(ddo_pkg::CSR_WHEEL_BASE, wb);
      csr_write(ddo_pkg::CSR_MODE, {31'd0, mode});
   endtask

   task automatic send_sample(bit [31:0] lc, bit [31:0] rc, bit [31:0] tu);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.left_count <= lc;
      req_if.right_count <= rc;
      req_if.time_us <= tu;
      do @(posedge clock); while (!req_if.ready);
      left_pos = lc;
      right_pos = rc;
      stamp = tu;
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (500) @(posedge clock);
   endtask

   task automatic random_samples(int count);
      int kind;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
         kind = $urandom_range(0, 11);
         case (kind)
            0: send_sample($urandom, $urandom, $urandom);
            1: send_sample(left_pos + $urandom_range(0, 400) - 200,
                           right_pos + $urandom_range(0, 400) - 200, stamp);
            2: send_sample(left_pos + $urandom, right_pos - $urandom,
                           stamp + $urandom_range(1, 3));
            3: send_sample(left_pos + 32'd37, right_pos + 32'd37,
                           stamp + $urandom_range(1, 100000));
            default: send_sample(left_pos + $urandom_range(0, 4000) - 2000,
                                 right_pos + $urandom_range(0, 4000) - 2000,
                                 stamp + $urandom_range(1, 20000));
         endcase
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.left_count <= '0;
      req_if.right_count <= '0;
      req_if.time_us <= '0;
      burst = 1'b0;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_odometry(32'h0400_0000, 32'h0400_0000, 32'h0002_0000, 1'b1);
      send_sample(32'd0, 32'd0, 32'd0);
      send_sample(32'd100, 32'd100, 32'd1000);
      send_sample(32'd100, 32'd100, 32'd1000);
      send_sample(32'd300, 32'd100, 32'd2000);
      send_sample(32'd100, 32'd300, 32'd2001);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd3000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd3000);
      send_sample(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF0);
      send_sample(32'd0, 32'hFFFF_FFFF, 32'h0000_0010);
      send_sample(32'd5000, -32'sd5000, 32'h0000_0011);
      send_sample(-32'sd5000, 32'd5000, 32'h0000_0012);
      send_sample(32'h4000_0000, 32'h4000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0, 32'h0, 32'h7FFF_FFFF);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
      send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);
      drain();
      set_odometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0);
      send_sample(left_pos + 32'h7FFF_FFFF, right_pos + 32'h7FFF_FFFF, stamp + 1);
      send_sample(left_pos - 32'd1, right_pos + 32'd1, stamp + 1);
      send_sample(left_pos + 32'd9, right_pos + 32'd9, stamp + 32'hFFFF_FFFF);
      drain();

      set_odometry(32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 1'b0);
      random_samples(80);
      drain();
      set_odometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
      random_samples(70);
      drain();
      set_odometry(32'hFFFF_FFFF, 32'd12345678, 32'hFFFF_FFFF, 1'b0);
      random_samples(70);
      drain();
      set_odometry(32'd0, 32'd0, 32'h0003_0000, 1'b1);
      random_samples(40);
      drain();
      set_odometry(32'h0010_0000, 32'h0020_0000, 32'h0003_0000, 1'b1);
      hold_request = 1'b1;
      random_samples(90);
      drain();
      set_odometry($urandom, $urandom, $urandom | 32'd1, 1'b0);
      random_samples(70);
      drain();
      set_odometry($urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0800_0000),
                   $urandom_range(32'h8000, 32'h0008_0000), 1'b1);
      random_samples(80);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      int wait_cycles;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (2000) @(posedge clock);
         end
         wait_cycles = burst ? 0 : $urandom_range(0, 6);
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end
endmodule
